[rtl/tun_pkg.sv]
`default_nettype none
package tun_pkg;

    localparam int COORD_WIDTH  = 24;
    localparam int NORMAL_WIDTH = 16;

    localparam int EW   = COORD_WIDTH + 1;
    localparam int PW   = 2 * EW;
    localparam int XW   = PW + 1;
    localparam int MAGW = 30;
    localparam int LW   = $clog2(XW + 1);
    localparam int SQW  = 2 * MAGW;
    localparam int SW   = SQW + 2;
    localparam int RW   = SW / 2;
    localparam int RMW  = RW + 2;
    localparam int DW   = MAGW + NORMAL_WIDTH;

    localparam logic [NORMAL_WIDTH-1:0] QMAX = {1'b0, {(NORMAL_WIDTH-1){1'b1}}};

    typedef struct packed {
        logic [2:0][MAGW-1:0] mag;
        logic [2:0]           neg;
        logic                 degen;
    } side_t;

    typedef struct packed {
        logic [RMW-1:0] rem;
        logic [RW-1:0]  root;
    } sq_t;

    typedef struct packed {
        logic [RW-1:0]           rem;
        logic [NORMAL_WIDTH-1:0] low;
        logic [NORMAL_WIDTH-1:0] q;
    } dv_t;

    function automatic sq_t sqrt_step(logic [RMW-1:0] rem, logic [RW-1:0] root,
                                      logic [1:0] pair);
        logic [RMW-1:0] cur;
        logic [RMW-1:0] trial;
        sq_t            res;
        cur   = {rem[RMW-3:0], pair};
        trial = {root, 2'b01};
        if (cur >= trial)
        begin
            res.rem  = cur - trial;
            res.root = {root[RW-2:0], 1'b1};
        end
        else
        begin
            res.rem  = cur;
            res.root = {root[RW-2:0], 1'b0};
        end
        return res;
    endfunction

    function automatic dv_t div_step(dv_t cur, logic [RW-1:0] den);
        logic [RW:0] t;
        dv_t         res;
        t       = {cur.rem, cur.low[NORMAL_WIDTH-1]};
        res.low = {cur.low[NORMAL_WIDTH-2:0], 1'b0};
        if (t >= {1'b0, den})
        begin
            res.rem = RW'(t - {1'b0, den});
            res.q   = {cur.q[NORMAL_WIDTH-2:0], 1'b1};
        end
        else
        begin
            res.rem = t[RW-1:0];
            res.q   = {cur.q[NORMAL_WIDTH-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[rtl/tun_cross.sv]
`default_nettype none
module tun_cross
(
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        valid_in,
    input  wire logic [2:0][tun_pkg::COORD_WIDTH-1:0]        a,
    input  wire logic [2:0][tun_pkg::COORD_WIDTH-1:0]        b,
    input  wire logic [2:0][tun_pkg::COORD_WIDTH-1:0]        c,
    output logic                                             valid_out,
    output logic [2:0][tun_pkg::XW-1:0]                      n
);
    localparam int CW = tun_pkg::COORD_WIDTH;
    localparam int EW = tun_pkg::EW;
    localparam int PW = tun_pkg::PW;
    localparam int XW = tun_pkg::XW;

    logic [2:0]              v_reg;
    logic [2:0][EW-1:0]      e1_reg;
    logic [2:0][EW-1:0]      e2_reg;
    logic [5:0][PW-1:0]      prod_reg;
    logic [2:0][XW-1:0]      n_reg;

    function automatic logic signed [PW-1:0] sx(logic [EW-1:0] v);
        return PW'($signed(v));
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[1:0], valid_in};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_reg[i] <= EW'($signed({b[i][CW-1], b[i]}) - $signed({a[i][CW-1], a[i]}));
            e2_reg[i] <= EW'($signed({c[i][CW-1], c[i]}) - $signed({a[i][CW-1], a[i]}));
        end
        prod_reg[0] <= sx(e1_reg[1]) * sx(e2_reg[2]);
        prod_reg[1] <= sx(e1_reg[2]) * sx(e2_reg[1]);
        prod_reg[2] <= sx(e1_reg[2]) * sx(e2_reg[0]);
        prod_reg[3] <= sx(e1_reg[0]) * sx(e2_reg[2]);
        prod_reg[4] <= sx(e1_reg[0]) * sx(e2_reg[1]);
        prod_reg[5] <= sx(e1_reg[1]) * sx(e2_reg[0]);
        for (int j = 0; j < 3; j++)
            n_reg[j] <= XW'($signed({prod_reg[2*j][PW-1], prod_reg[2*j]})
                           - $signed({prod_reg[2*j+1][PW-1], prod_reg[2*j+1]}));
    end

    assign valid_out = v_reg[2];
    assign n         = n_reg;

endmodule
`default_nettype wire

[rtl/tun_scale.sv]
`default_nettype none
module tun_scale
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          valid_in,
    input  wire logic [2:0][tun_pkg::XW-1:0]   n,
    output logic                               valid_out,
    output logic [tun_pkg::SW-1:0]             sum,
    output tun_pkg::side_t                     side
);
    localparam int XW   = tun_pkg::XW;
    localparam int LW   = tun_pkg::LW;
    localparam int MAGW = tun_pkg::MAGW;
    localparam int SQW  = tun_pkg::SQW;
    localparam int SW   = tun_pkg::SW;

    logic [4:0]              v_reg;
    logic [2:0][XW-1:0]      abs_reg;
    logic [2:0][XW-1:0]      abs2_reg;
    logic [2:0]              neg_reg;
    logic [2:0]              neg2_reg;
    logic [XW-1:0]           or_reg;
    logic [LW-1:0]           len_reg;
    tun_pkg::side_t          side3_reg;
    tun_pkg::side_t          side4_reg;
    tun_pkg::side_t          side5_reg;
    logic [2:0][SQW-1:0]     sq_reg;
    logic [SW-1:0]           sum_reg;
    logic [LW-1:0]           len_next;
    logic [LW-1:0]           shift;

    always_comb
    begin
        len_next = '0;
        for (int i = 0; i < XW; i++)
            if (or_reg[i])
                len_next = LW'(i + 1);
    end

    assign shift = (len_reg > LW'(MAGW)) ? LW'(len_reg - LW'(MAGW)) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[3:0], valid_in};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg_reg[i] <= n[i][XW-1];
            abs_reg[i] <= n[i][XW-1] ? XW'(-n[i]) : n[i];
        end
        or_reg <= (n[0][XW-1] ? XW'(-n[0]) : n[0]) | (n[1][XW-1] ? XW'(-n[1]) : n[1])
                | (n[2][XW-1] ? XW'(-n[2]) : n[2]);
        abs2_reg <= abs_reg;
        neg2_reg <= neg_reg;
        len_reg  <= len_next;
        for (int i = 0; i < 3; i++)
            side3_reg.mag[i] <= MAGW'(abs2_reg[i] >> shift);
        side3_reg.neg   <= neg2_reg;
        side3_reg.degen <= (len_reg == '0);
        for (int i = 0; i < 3; i++)
            sq_reg[i] <= SQW'(side3_reg.mag[i]) * SQW'(side3_reg.mag[i]);
        side4_reg <= side3_reg;
        sum_reg   <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
        side5_reg <= side4_reg;
    end

    assign valid_out = v_reg[4];
    assign sum       = sum_reg;
    assign side      = side5_reg;

endmodule
`default_nettype wire

[rtl/tun_isqrt.sv]
`default_nettype none
module tun_isqrt
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      valid_in,
    input  wire logic [tun_pkg::SW-1:0]    sum,
    input  wire tun_pkg::side_t            side_in,
    output logic                           valid_out,
    output logic [tun_pkg::RW-1:0]         root,
    output tun_pkg::side_t                 side_out
);
    localparam int SW  = tun_pkg::SW;
    localparam int RW  = tun_pkg::RW;
    localparam int RMW = tun_pkg::RMW;

    logic [RW-1:0]              v_reg;
    logic [RW-1:0][RMW-1:0]     rem_reg;
    logic [RW-1:0][RW-1:0]      root_reg;
    logic [RW-1:0][SW-1:0]      rad_reg;
    tun_pkg::side_t             side_reg [RW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[RW-2:0], valid_in};
    end

    always_ff @(posedge clk)
    begin
        {rem_reg[0], root_reg[0]} <= tun_pkg::sqrt_step('0, '0, sum[SW-1:SW-2]);
        rad_reg[0]  <= {sum[SW-3:0], 2'b00};
        side_reg[0] <= side_in;
        for (int s = 1; s < RW; s++)
        begin
            {rem_reg[s], root_reg[s]} <= tun_pkg::sqrt_step(rem_reg[s-1], root_reg[s-1],
                                                            rad_reg[s-1][SW-1:SW-2]);
            rad_reg[s]  <= {rad_reg[s-1][SW-3:0], 2'b00};
            side_reg[s] <= side_reg[s-1];
        end
    end

    assign valid_out = v_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule
`default_nettype wire

[rtl/tun_div.sv]
`default_nettype none
module tun_div
(
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       valid_in,
    input  wire logic [tun_pkg::RW-1:0]                     root,
    input  wire tun_pkg::side_t                             side,
    output logic                                            valid_out,
    output logic [2:0][tun_pkg::NORMAL_WIDTH-1:0]           q,
    output logic [2:0]                                      neg,
    output logic                                            degen
);
    localparam int NW   = tun_pkg::NORMAL_WIDTH;
    localparam int RW   = tun_pkg::RW;
    localparam int DW   = tun_pkg::DW;

    logic [NW-1:0]                  v_reg;
    tun_pkg::dv_t                   lane_reg [NW][3];
    logic [NW-1:0][RW-1:0]          den_reg;
    logic [NW-1:0][2:0]             neg_reg;
    logic [NW-1:0]                  degen_reg;
    tun_pkg::dv_t                   init [3];
    logic [2:0][DW-1:0]             dvd;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dvd[i]      = {1'b0, side.mag[i], {(NW-1){1'b0}}} + DW'(root >> 1);
            init[i].rem = RW'(dvd[i][DW-1:NW]);
            init[i].low = dvd[i][NW-1:0];
            init[i].q   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[NW-2:0], valid_in};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            lane_reg[0][i] <= tun_pkg::div_step(init[i], root);
        den_reg[0]   <= root;
        neg_reg[0]   <= side.neg;
        degen_reg[0] <= side.degen;
        for (int s = 1; s < NW; s++)
        begin
            for (int i = 0; i < 3; i++)
                lane_reg[s][i] <= tun_pkg::div_step(lane_reg[s-1][i], den_reg[s-1]);
            den_reg[s]   <= den_reg[s-1];
            neg_reg[s]   <= neg_reg[s-1];
            degen_reg[s] <= degen_reg[s-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            q[i] = lane_reg[NW-1][i].q;
    end

    assign valid_out = v_reg[NW-1];
    assign neg       = neg_reg[NW-1];
    assign degen     = degen_reg[NW-1];

endmodule
`default_nettype wire

[rtl/triangle_unit_normal.sv]
`default_nettype none
// Unit face normal of one triangle (corners in signed Q8.16, normal in Q1.15,
// saturated). A triangle is taken every cycle and busy never rises; each
// result appears with done for one cycle once start has passed the stages: 3 for the
// edge/cross-product multipliers, 5 for magnitude scaling and squared length,
// 31 for the one-bit-per-stage square root, 16 for the one-bit-per-stage
// dividers and 1 output register. The receiver cannot stall; a zero-area
// triangle gives a zero normal with degenerate set.
module triangle_unit_normal
(
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       start,
    output logic                                            busy,
    input  wire logic signed [tun_pkg::COORD_WIDTH-1:0]     a_x,
    input  wire logic signed [tun_pkg::COORD_WIDTH-1:0]     a_y,
    input  wire logic signed [tun_pkg::COORD_WIDTH-1:0]     a_z,
    input  wire logic signed [tun_pkg::COORD_WIDTH-1:0]     b_x,
    input  wire logic signed [tun_pkg::COORD_WIDTH-1:0]     b_y,
    input  wire logic signed [tun_pkg::COORD_WIDTH-1:0]     b_z,
    input  wire logic signed [tun_pkg::COORD_WIDTH-1:0]     c_x,
    input  wire logic signed [tun_pkg::COORD_WIDTH-1:0]     c_y,
    input  wire logic signed [tun_pkg::COORD_WIDTH-1:0]     c_z,
    output logic                                            done,
    output logic signed [tun_pkg::NORMAL_WIDTH-1:0]         normal_x,
    output logic signed [tun_pkg::NORMAL_WIDTH-1:0]         normal_y,
    output logic signed [tun_pkg::NORMAL_WIDTH-1:0]         normal_z,
    output logic                                            degenerate
);
    localparam int NW = tun_pkg::NORMAL_WIDTH;

    logic                                   x_valid;
    logic [2:0][tun_pkg::XW-1:0]            x_n;
    logic                                   s_valid;
    logic [tun_pkg::SW-1:0]                 s_sum;
    tun_pkg::side_t                         s_side;
    logic                                   r_valid;
    logic [tun_pkg::RW-1:0]                 r_root;
    tun_pkg::side_t                         r_side;
    logic                                   d_valid;
    logic [2:0][NW-1:0]                     d_q;
    logic [2:0]                             d_neg;
    logic                                   d_degen;
    logic [2:0][NW-1:0]                     comp_next;
    logic [2:0][NW-1:0]                     comp_reg;
    logic                                   done_reg;
    logic                                   degen_reg;

    assign busy = 1'b0;

    tun_cross u_cross
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (start),
        .a         ({a_z, a_y, a_x}),
        .b         ({b_z, b_y, b_x}),
        .c         ({c_z, c_y, c_x}),
        .valid_out (x_valid),
        .n         (x_n)
    );

    tun_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (x_valid),
        .n         (x_n),
        .valid_out (s_valid),
        .sum       (s_sum),
        .side      (s_side)
    );

    tun_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s_valid),
        .sum       (s_sum),
        .side_in   (s_side),
        .valid_out (r_valid),
        .root      (r_root),
        .side_out  (r_side)
    );

    tun_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (r_valid),
        .root      (r_root),
        .side      (r_side),
        .valid_out (d_valid),
        .q         (d_q),
        .neg       (d_neg),
        .degen     (d_degen)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            comp_next[i] = (d_q[i] > tun_pkg::QMAX) ? tun_pkg::QMAX : d_q[i];
            if (d_neg[i])
                comp_next[i] = NW'(-comp_next[i]);
            if (d_degen)
                comp_next[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        comp_reg  <= comp_next;
        degen_reg <= d_degen;
    end

    assign done       = done_reg;
    assign normal_x   = comp_reg[0];
    assign normal_y   = comp_reg[1];
    assign normal_z   = comp_reg[2];
    assign degenerate = degen_reg;

endmodule
`default_nettype wire
